/* rtl/dolp_pkg.sv */
// Shared types, option tags and result codes for the DHCP option lease parser.
// No dependencies; imported by every module of the block.
package dolp_pkg;

    // Option tags
    localparam logic [7:0] TAG_PAD    = 8'd0;
    localparam logic [7:0] TAG_MASK   = 8'd1;
    localparam logic [7:0] TAG_ROUTER = 8'd3;
    localparam logic [7:0] TAG_DNS    = 8'd6;
    localparam logic [7:0] TAG_LEASE  = 8'd51;
    localparam logic [7:0] TAG_TYPE   = 8'd53;
    localparam logic [7:0] TAG_SERVER = 8'd54;
    localparam logic [7:0] TAG_T1     = 8'd58;
    localparam logic [7:0] TAG_T2     = 8'd59;
    localparam logic [7:0] TAG_END    = 8'd255;

    // Capture slots
    localparam int          NUM_SLOTS   = 8;
    localparam logic [2:0]  SLOT_TYPE   = 3'd0;
    localparam logic [2:0]  SLOT_MASK   = 3'd1;
    localparam logic [2:0]  SLOT_ROUTER = 3'd2;
    localparam logic [2:0]  SLOT_DNS    = 3'd3;
    localparam logic [2:0]  SLOT_SERVER = 3'd4;
    localparam logic [2:0]  SLOT_LEASE  = 3'd5;
    localparam logic [2:0]  SLOT_T1     = 3'd6;
    localparam logic [2:0]  SLOT_T2     = 3'd7;

    // Message types and defaults
    localparam logic [7:0]  MSG_NAK        = 8'd6;
    localparam logic [7:0]  WANTED_RESET   = 8'd2;
    localparam logic [31:0] LEASE_RESET    = 32'd3600;
    localparam logic [31:0] LEASE_FALLBACK = 32'd3600;
    localparam logic [31:0] MASK_DEFAULT   = 32'hFFFF_FF00;

    // Configuration register indexes
    localparam logic CFG_WANTED_TYPE   = 1'b0;
    localparam logic CFG_DEFAULT_LEASE = 1'b1;

    // Output word width: 230 payload bits padded to whole bytes
    localparam int OUT_BITS = 232;

    typedef enum logic [1:0] {
        ST_ACCEPT  = 2'd0,
        ST_NAK     = 2'd1,
        ST_NO_TYPE = 2'd2,
        ST_OTHER   = 2'd3
    } status_t;

    // Raw captures of one reply; values are zero where the flag is clear
    typedef struct packed {
        logic [7:0]  flags;
        logic [7:0]  msg_type;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns;
        logic [31:0] server;
        logic [31:0] lease;
        logic [31:0] t1;
        logic [31:0] t2;
    } capture_t;

    // Slot lookup: hit flag in bit 3, slot in bits 2:0
    function automatic logic [3:0] slot_of(input logic [7:0] tag);
        logic [3:0] res;
        unique case (tag)
            TAG_TYPE:   res = {1'b1, SLOT_TYPE};
            TAG_MASK:   res = {1'b1, SLOT_MASK};
            TAG_ROUTER: res = {1'b1, SLOT_ROUTER};
            TAG_DNS:    res = {1'b1, SLOT_DNS};
            TAG_SERVER: res = {1'b1, SLOT_SERVER};
            TAG_LEASE:  res = {1'b1, SLOT_LEASE};
            TAG_T1:     res = {1'b1, SLOT_T1};
            TAG_T2:     res = {1'b1, SLOT_T2};
            default:    res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/dolp_front.sv */
// Front end: walks the option bytes, one word per cycle unless q_full, and keeps
// first captures. Needs dolp_pkg; pushes a capture record per reply to dolp_queue.
module dolp_front
    import dolp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       in_ready,
    output logic       push,
    output capture_t   push_rec
);

    typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_VAL, PH_STOP} phase_t;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  tag_reg,    tag_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  left_reg,   left_next;
    logic [31:0] shift_reg,  shift_next;
    logic [7:0]  flags_reg,  flags_next;
    logic [7:0]  flags_upd;
    logic [31:0] vals_reg [NUM_SLOTS];

    logic        accept;
    logic        commit_en;
    logic [3:0]  slot_hit;
    logic [2:0]  slot;
    logic [31:0] commit_val;
    logic [7:0]  offset;
    logic [31:0] cur_val [NUM_SLOTS];

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign slot_hit = slot_of(tag_reg);
    assign slot     = slot_hit[2:0];
    assign offset   = len_reg - left_reg;

    // Parser step
    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        shift_next = shift_reg;
        commit_en  = 1'b0;
        commit_val = shift_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    if (in_byte == TAG_END)
                        phase_next = PH_STOP;
                    else if (in_byte != TAG_PAD)
                    begin
                        tag_next   = in_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    len_next   = in_byte;
                    left_next  = in_byte;
                    shift_next = '0;
                    phase_next = (in_byte == 8'd0) ? PH_TAG : PH_VAL;
                end
                PH_VAL:
                begin
                    if (offset < 8'd4)
                        shift_next = {shift_reg[23:0], in_byte};
                    left_next = left_reg - 8'd1;
                    if (left_next == 8'd0)
                    begin
                        phase_next = PH_TAG;
                        // type needs one byte, the others four
                        if (slot_hit[3] && !flags_reg[slot] &&
                            (slot == SLOT_TYPE || len_reg[7:2] != 6'd0))
                            commit_en = 1'b1;
                        if (slot == SLOT_TYPE)
                        begin
                            // first value byte sits above the later ones
                            if (len_reg[7:2] != 6'd0)
                                commit_val = {24'd0, shift_next[31:24]};
                            else if (len_reg[1:0] == 2'd3)
                                commit_val = {24'd0, shift_next[23:16]};
                            else if (len_reg[1:0] == 2'd2)
                                commit_val = {24'd0, shift_next[15:8]};
                            else
                                commit_val = {24'd0, shift_next[7:0]};
                        end
                        else
                            commit_val = shift_next;
                    end
                end
                PH_STOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Captures as they stand after this word
    always_comb
    begin
        flags_upd = flags_reg;
        if (commit_en)
            flags_upd[slot] = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (commit_en && slot == i[2:0])
                cur_val[i] = commit_val;
            else
                cur_val[i] = vals_reg[i];
            if (!flags_upd[i])
                cur_val[i] = '0;
        end
        flags_next = (accept && in_last) ? 8'd0 : flags_upd;
    end

    // Record pushed into the queue on the last word
    assign push              = accept && in_last;
    assign push_rec.flags    = flags_upd;
    assign push_rec.msg_type = cur_val[SLOT_TYPE][7:0];
    assign push_rec.mask     = cur_val[SLOT_MASK];
    assign push_rec.router   = cur_val[SLOT_ROUTER];
    assign push_rec.dns      = cur_val[SLOT_DNS];
    assign push_rec.server   = cur_val[SLOT_SERVER];
    assign push_rec.lease    = cur_val[SLOT_LEASE];
    assign push_rec.t1       = cur_val[SLOT_T1];
    assign push_rec.t2       = cur_val[SLOT_T2];

    // Parser state; cleared after the last word of each reply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            tag_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            shift_reg <= '0;
            flags_reg <= '0;
        end
        else if (accept && in_last)
        begin
            phase_reg <= PH_TAG;
            tag_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            shift_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            shift_reg <= shift_next;
            flags_reg <= flags_next;
        end
    end

    // Captured values; flags mark which are live
    always_ff @(posedge clk)
    begin
        if (commit_en)
            vals_reg[slot] <= commit_val;
    end

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> flags_reg == 8'd0 && phase_reg == PH_TAG)
        else $error("parser state not cleared after last word");

    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_last && phase_reg == PH_STOP |=> phase_reg == PH_STOP)
        else $error("parser left the stopped phase before last word");

    a_flags_keep: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_last |=> (flags_reg & $past(flags_reg)) == $past(flags_reg))
        else $error("capture flag dropped within a reply");

endmodule

/* rtl/dolp_queue.sv */
// Two-entry queue of capture records between the parser and the finisher.
// Depends on dolp_pkg.
module dolp_queue
    import dolp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  capture_t push_rec,
    input  logic     pop,
    output logic     full,
    output logic     head_valid,
    output capture_t head_rec
);

    capture_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push, do_pop;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_rec   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_rec;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3 && (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue count and pointers disagree");

endmodule

/* rtl/dolp_back.sv */
// Back end: turns a capture record into status, defaults and clamped timers.
// Depends on dolp_pkg; two registered stages, the second is the output register.
module dolp_back
    import dolp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          wanted_type,
    input  logic [31:0]         default_lease,
    input  logic                head_valid,
    input  capture_t            head_rec,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_BITS-1:0] out_data
);

    // Stage A
    logic        a_valid_reg;
    status_t     a_status_reg;
    logic [3:0]  a_found_reg;
    logic [31:0] a_mask_reg, a_router_reg, a_dns_reg, a_server_reg;
    logic [31:0] a_lease_reg, a_t1_reg, a_t2_reg;
    // Stage B (output)
    logic        b_valid_reg;
    status_t     b_status_reg;
    logic [3:0]  b_found_reg;
    logic [31:0] b_mask_reg, b_router_reg, b_dns_reg, b_server_reg;
    logic [31:0] b_lease_reg, b_t1_reg, b_t2_reg;

    logic        a_ready, b_ready;
    status_t     status_next;
    logic [31:0] lease_next, t1_next, t2_next, mask_next;
    logic [34:0] lease_x7;
    logic [31:0] t2_final;

    assign b_ready = !b_valid_reg || out_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = head_valid && a_ready;

    // Status, mask and lease defaults, T1 clamp, T2 default
    always_comb
    begin
        if (!head_rec.flags[SLOT_TYPE])
            status_next = ST_NO_TYPE;
        else if (head_rec.msg_type == MSG_NAK)
            status_next = ST_NAK;
        else if (head_rec.msg_type != wanted_type)
            status_next = ST_OTHER;
        else
            status_next = ST_ACCEPT;

        mask_next = (head_rec.mask == 32'd0) ? MASK_DEFAULT : head_rec.mask;

        if (head_rec.lease != 32'd0)
            lease_next = head_rec.lease;
        else if (default_lease != 32'd0)
            lease_next = default_lease;
        else
            lease_next = LEASE_FALLBACK;

        if (head_rec.t1 == 32'd0 || head_rec.t1 > lease_next)
            t1_next = {1'b0, lease_next[31:1]};
        else
            t1_next = head_rec.t1;

        // lease * 7 kept exact in 35 bits
        lease_x7 = {lease_next, 3'b000} - {3'b000, lease_next};
        t2_next  = (head_rec.t2 == 32'd0) ? lease_x7[34:3] : head_rec.t2;
    end

    // T2 ordering check
    assign t2_final = (a_t2_reg < a_t1_reg || a_t2_reg > a_lease_reg) ? a_lease_reg
                                                                      : a_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= head_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_status_reg <= status_next;
            a_found_reg  <= {head_rec.flags[SLOT_MASK], head_rec.flags[SLOT_SERVER],
                             head_rec.flags[SLOT_DNS], head_rec.flags[SLOT_ROUTER]};
            a_mask_reg   <= mask_next;
            a_router_reg <= head_rec.router;
            a_dns_reg    <= head_rec.dns;
            a_server_reg <= head_rec.server;
            a_lease_reg  <= lease_next;
            a_t1_reg     <= t1_next;
            a_t2_reg     <= t2_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_status_reg <= a_status_reg;
            b_found_reg  <= a_found_reg;
            b_mask_reg   <= a_mask_reg;
            b_router_reg <= a_router_reg;
            b_dns_reg    <= a_dns_reg;
            b_server_reg <= a_server_reg;
            b_lease_reg  <= a_lease_reg;
            b_t1_reg     <= a_t1_reg;
            b_t2_reg     <= t2_final;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = {2'b00, b_t2_reg, b_t1_reg, b_lease_reg, b_server_reg,
                        b_dns_reg, b_router_reg, b_mask_reg, b_found_reg, b_status_reg};

    a_t2_order: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> b_t2_reg <= b_lease_reg && b_t1_reg <= b_lease_reg)
        else $error("timer above lease on output");

endmodule

/* rtl/dhcp_option_lease_parser.sv */
// Top level of the DHCP option lease parser: configuration registers and wiring.
// Depends on dolp_pkg, dolp_front, dolp_queue and dolp_back.
//
// Takes the options area of a DHCP reply one byte per word on the s_ side,
// s_tlast on the final byte, at one word per cycle while the queue is not
// full. On the final byte the parser hands its captures to a two-entry
// queue; a two-stage finisher applies the mask, lease and T1/T2 defaults and
// clamps and presents one result word on the m_ side, m_tvalid rising once
// that last byte has passed the queue write, the finisher stage and the output
// register. Input back-pressure only arises when the queue is full, i.e. when
// results are not being taken. Configuration writes are registered and should
// be made while no reply is in flight.
module dhcp_option_lease_parser
    import dolp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // stream in
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] opt_byte
    input  logic                s_tlast,   // last
    // stream out
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata,   // [1:0] status, [5:2] found_flags,
                                           // [37:6] net_mask, [69:38] router_addr,
                                           // [101:70] dns_addr, [133:102] server_addr,
                                           // [165:134] lease_time, [197:166] renew_time,
                                           // [229:198] rebind_time, [231:230] zero
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [7:0]  wanted_type_reg;
    logic [31:0] default_lease_reg;
    logic        q_full, push, head_valid, pop;
    capture_t    push_rec, head_rec;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_type_reg   <= WANTED_RESET;
            default_lease_reg <= LEASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WANTED_TYPE:   wanted_type_reg   <= cfg_data[7:0];
                CFG_DEFAULT_LEASE: default_lease_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    dolp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push),
        .push_rec (push_rec)
    );

    dolp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    dolp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wanted_type   (wanted_type_reg),
        .default_lease (default_lease_reg),
        .head_valid    (head_valid),
        .head_rec      (head_rec),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (m_tdata)
    );

endmodule

/* tb/dhcp_option_lease_parser_tb.sv */
// Self-checking testbench for the DHCP option lease parser: streams option bytes,
// predicts each lease result in a behavioral parser and compares every field.
// Depends on dolp_pkg and the dhcp_option_lease_parser RTL.
`timescale 1ns / 1ps

module dhcp_option_lease_parser_tb;
    import dolp_pkg::*;

    // Cycles with no handshake and no register write before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    // Pipeline settle time after the last result
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        WALK_TAG,
        WALK_LEN,
        WALK_VALUE,
        WALK_DONE
    } walk_phase_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  found;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns;
        logic [31:0] server;
        logic [31:0] lease;
        logic [31:0] renew;
        logic [31:0] rebind;
    } lease_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [7:0] opt_byte
    logic                s_tlast;   // last
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;   // [1:0] status, [5:2] found_flags, [37:6] net_mask,
                                    // [69:38] router_addr, [101:70] dns_addr,
                                    // [133:102] server_addr, [165:134] lease_time,
                                    // [197:166] renew_time, [229:198] rebind_time
    logic                cfg_we;
    logic                cfg_index;
    logic [31:0]         cfg_data;

    // Register shadows
    logic [7:0]  wanted_type_cfg;
    logic [31:0] default_lease_cfg;

    // Option walker state
    walk_phase_t walk_phase;
    logic [7:0]  opt_tag;
    logic [7:0]  opt_len;
    logic [7:0]  opt_left;
    logic [31:0] opt_shift;
    logic [31:0] slot_val [NUM_SLOTS];
    logic [7:0]  slot_taken;

    lease_result_t pending_leases [$];
    logic [7:0]    reply_bytes [$];
    int            mismatch_count = 0;
    int            bytes_sent = 0;
    int            stall_cycles = 0;
    logic          burst_mode = 1'b0;

    dhcp_option_lease_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral parser
    // ------------------------------------------------------------------

    function automatic int slot_for_tag(input logic [7:0] tag);
        case (tag)
            TAG_TYPE:   return int'(SLOT_TYPE);
            TAG_MASK:   return int'(SLOT_MASK);
            TAG_ROUTER: return int'(SLOT_ROUTER);
            TAG_DNS:    return int'(SLOT_DNS);
            TAG_SERVER: return int'(SLOT_SERVER);
            TAG_LEASE:  return int'(SLOT_LEASE);
            TAG_T1:     return int'(SLOT_T1);
            TAG_T2:     return int'(SLOT_T2);
            default:    return -1;
        endcase
    endfunction

    task automatic clear_walk();
        walk_phase = WALK_TAG;
        opt_tag    = 8'd0;
        opt_len    = 8'd0;
        opt_left   = 8'd0;
        opt_shift  = 32'd0;
        slot_taken = 8'd0;
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_val[i] = 32'd0;
    endtask

    // Keep the first complete occurrence of a tracked option
    task automatic store_option();
        int slot;
        int got;
        slot = slot_for_tag(opt_tag);
        if (slot < 0 || slot_taken[slot])
            return;
        if (slot == int'(SLOT_TYPE))
        begin
            if (opt_len == 8'd0)
                return;
            got = (opt_len < 8'd4) ? int'(opt_len) : 4;
            // first value byte sits at the top of what was shifted in
            slot_val[slot] = (opt_shift >> (8 * (got - 1))) & 32'hFF;
        end
        else
        begin
            if (opt_len < 8'd4)
                return;
            slot_val[slot] = opt_shift;
        end
        slot_taken[slot] = 1'b1;
    endtask

    task automatic walk_byte(input logic [7:0] b);
        case (walk_phase)
            WALK_TAG:
            begin
                if (b == TAG_END)
                    walk_phase = WALK_DONE;
                else if (b != TAG_PAD)
                begin
                    opt_tag    = b;
                    walk_phase = WALK_LEN;
                end
            end
            WALK_LEN:
            begin
                opt_len    = b;
                opt_left   = b;
                opt_shift  = 32'd0;
                walk_phase = (b == 8'd0) ? WALK_TAG : WALK_VALUE;
            end
            WALK_VALUE:
            begin
                if (8'(opt_len - opt_left) < 8'd4)
                    opt_shift = {opt_shift[23:0], b};
                opt_left = opt_left - 8'd1;
                if (opt_left == 8'd0)
                begin
                    store_option();
                    walk_phase = WALK_TAG;
                end
            end
            default: ;
        endcase
    endtask

    // Status, defaults and T1/T2 clamps applied on the final byte
    function automatic lease_result_t finish_reply();
        lease_result_t r;
        logic [35:0]   seven_lease;
        if (!slot_taken[SLOT_TYPE])
            r.status = ST_NO_TYPE;
        else if (slot_val[SLOT_TYPE] == 32'(MSG_NAK))
            r.status = ST_NAK;
        else if (slot_val[SLOT_TYPE] != 32'(wanted_type_cfg))
            r.status = ST_OTHER;
        else
            r.status = ST_ACCEPT;
        r.found  = {slot_taken[SLOT_MASK], slot_taken[SLOT_SERVER],
                    slot_taken[SLOT_DNS], slot_taken[SLOT_ROUTER]};
        r.mask   = (slot_val[SLOT_MASK] == 32'd0) ? MASK_DEFAULT : slot_val[SLOT_MASK];
        r.router = slot_val[SLOT_ROUTER];
        r.dns    = slot_val[SLOT_DNS];
        r.server = slot_val[SLOT_SERVER];
        r.lease  = slot_val[SLOT_LEASE];
        if (r.lease == 32'd0)
            r.lease = (default_lease_cfg != 32'd0) ? default_lease_cfg : LEASE_FALLBACK;
        r.renew  = slot_val[SLOT_T1];
        r.rebind = slot_val[SLOT_T2];
        if (r.renew == 32'd0)
            r.renew = r.lease >> 1;
        if (r.rebind == 32'd0)
        begin
            // 7/8 of the lease, product kept wide so it cannot wrap
            seven_lease = {4'd0, r.lease} * 36'd7;
            r.rebind    = seven_lease[34:3];
        end
        if (r.renew == 32'd0 || r.renew > r.lease)
            r.renew = r.lease >> 1;
        if (r.rebind < r.renew || r.rebind > r.lease)
            r.rebind = r.lease;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and result check
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor_blk
        lease_result_t want;
        lease_result_t seen;
        if (rst_n)
        begin
            // input word accepted: advance the walker, queue a result on last
            if (s_tvalid && s_tready)
            begin
                walk_byte(s_tdata);
                if (s_tlast)
                begin
                    pending_leases.push_back(finish_reply());
                    clear_walk();
                end
            end
            // output word accepted: compare with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                seen.status = status_t'(m_tdata[1:0]);
                seen.found  = m_tdata[5:2];
                seen.mask   = m_tdata[37:6];
                seen.router = m_tdata[69:38];
                seen.dns    = m_tdata[101:70];
                seen.server = m_tdata[133:102];
                seen.lease  = m_tdata[165:134];
                seen.renew  = m_tdata[197:166];
                seen.rebind = m_tdata[229:198];
                if (pending_leases.size() == 0)
                begin
                    $error("result word with no reply pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_leases.pop_front();
                    check_field("status", 32'(want.status), 32'(seen.status));
                    check_field("found_flags", 32'(want.found), 32'(seen.found));
                    check_field("net_mask", want.mask, seen.mask);
                    check_field("router_addr", want.router, seen.router);
                    check_field("dns_addr", want.dns, seen.dns);
                    check_field("server_addr", want.server, seen.server);
                    check_field("lease_time", want.lease, seen.lease);
                    check_field("renew_time", want.renew, seen.renew);
                    check_field("rebind_time", want.rebind, seen.rebind);
                end
            end
        end
    end

    // Receiver: random stalls outside burst stretches
    always @(posedge clk)
        m_tready <= burst_mode || ($urandom_range(0, 99) >= 31);

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input word, with a random gap ahead of it
    task automatic send_word(input logic [7:0] b, input logic last_flag);
        while (!burst_mode && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last_flag;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_reply();
        for (int i = 0; i < reply_bytes.size(); i++)
            send_word(reply_bytes[i], i == reply_bytes.size() - 1);
    endtask

    // Stop sending and let every pending result drain
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_leases.size() != 0);
    endtask

    // Idle point for register writes: drained plus pipeline settle time
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_WANTED_TYPE)
            wanted_type_cfg = data[7:0];
        else
            default_lease_cfg = data;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Option: tag, length, first four value bytes big-endian, rest random
    task automatic push_option(input logic [7:0] tag, input int len, input logic [31:0] val);
        reply_bytes.push_back(tag);
        reply_bytes.push_back(8'(len));
        for (int i = 0; i < len; i++)
            reply_bytes.push_back((i < 4) ? val[31 - 8 * i -: 8] : 8'($urandom));
    endtask

    function automatic logic [7:0] random_kept_tag();
        case ($urandom_range(0, 6))
            0:       return TAG_MASK;
            1:       return TAG_ROUTER;
            2:       return TAG_DNS;
            3:       return TAG_SERVER;
            4:       return TAG_LEASE;
            5:       return TAG_T1;
            default: return TAG_T2;
        endcase
    endfunction

    // Mostly full four-byte values, some long, some short
    function automatic int random_value_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return 4;
        if (r == 8)
            return $urandom_range(5, 8);
        return $urandom_range(0, 3);
    endfunction

    // Times lean small so T1/T2 land on both sides of the lease
    function automatic logic [31:0] random_value(input logic [7:0] tag);
        logic is_time;
        is_time = (tag == TAG_LEASE || tag == TAG_T1 || tag == TAG_T2);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return is_time ? 32'($urandom_range(1, 10000)) : 32'($urandom);
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_msg_type();
        case ($urandom_range(0, 4))
            0, 1:    return wanted_type_cfg;
            2:       return MSG_NAK;
            3:       return 8'($urandom);
            default: return wanted_type_cfg + 8'd1;
        endcase
    endfunction

    // Mostly well-formed option lists with random content, some raw noise
    task automatic build_random_reply();
        int          n_opts;
        int          len;
        int          cut;
        logic [7:0]  tag;
        reply_bytes.delete();
        if ($urandom_range(0, 99) < 25)
        begin
            repeat ($urandom_range(1, 12))
                reply_bytes.push_back(8'($urandom));
            return;
        end
        n_opts = $urandom_range(0, 6);
        repeat (n_opts)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                    push_option(TAG_TYPE, len, {random_msg_type(), 24'($urandom)});
                end
                8:
                    reply_bytes.push_back(TAG_PAD);
                9:
                    push_option(8'($urandom_range(1, 254)), $urandom_range(0, 6), $urandom);
                default:
                begin
                    tag = random_kept_tag();
                    push_option(tag, random_value_len(), random_value(tag));
                end
            endcase
        end
        // ending: END with trailing junk, plain stop, or an option cut short
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                reply_bytes.push_back(TAG_END);
                repeat ($urandom_range(0, 3))
                    reply_bytes.push_back(8'($urandom));
            end
            6, 7: ;
            default:
            begin
                tag = ($urandom_range(0, 3) == 0) ? TAG_TYPE : random_kept_tag();
                len = $urandom_range(1, 6);
                cut = $urandom_range(0, len - 1);
                reply_bytes.push_back(tag);
                reply_bytes.push_back(8'(len));
                repeat (cut)
                    reply_bytes.push_back(8'($urandom));
            end
        endcase
        if (reply_bytes.size() == 0)
            reply_bytes.push_back(TAG_END);
    endtask

    task automatic run_random_replies(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            build_random_reply();
            send_reply();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built replies for the corner cases of the walk
    task automatic test_directed_cases();
        // END alone: no message type
        reply_bytes = '{TAG_END};
        send_reply();
        // one pad byte and nothing else
        reply_bytes = '{TAG_PAD};
        send_reply();
        // NAK reply
        reply_bytes.delete();
        push_option(TAG_TYPE, 1, {MSG_NAK, 24'd0});
        reply_bytes.push_back(TAG_END);
        send_reply();
        // wanted type, short router skipped, lease truncated by last
        reply_bytes.delete();
        push_option(TAG_TYPE, 1, {wanted_type_cfg, 24'd0});
        push_option(TAG_ROUTER, 2, 32'hAABB_0000);
        reply_bytes.push_back(TAG_LEASE);
        reply_bytes.push_back(8'd4);
        reply_bytes.push_back(8'hFF);
        reply_bytes.push_back(8'hFF);
        send_reply();
        // bytes after END are ignored
        reply_bytes = '{TAG_END, TAG_TYPE, 8'd1, wanted_type_cfg};
        send_reply();
    endtask

    // Register settings including both extremes and the zero default lease
    task automatic test_config_settings();
        logic [7:0]  wanted_list [6] = '{8'd5, 8'd255, 8'd6, 8'd1, 8'd2, 8'd5};
        logic [31:0] lease_list  [6] = '{32'd86400, 32'd0, 32'hFFFF_FFFF, 32'd1,
                                         32'd7, LEASE_RESET};
        for (int i = 0; i < 6; i++)
        begin
            wait_idle();
            write_reg(CFG_WANTED_TYPE, {24'd0, wanted_list[i]});
            write_reg(CFG_DEFAULT_LEASE, lease_list[i]);
            run_random_replies(70);
        end
    endtask

    // Full-rate stretch: no gaps on either side
    task automatic test_back_to_back();
        burst_mode = 1'b1;
        run_random_replies(150);
        burst_mode = 1'b0;
    endtask

    // Sender holds off until every result is out, now and then
    task automatic test_pause_for_results();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 100)
        begin
            build_random_reply();
            send_reply();
            if ($urandom_range(0, 1) == 0)
                wait_results();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_WANTED_TYPE;
        cfg_data  <= 32'd0;
        wanted_type_cfg   = WANTED_RESET;
        default_lease_cfg = LEASE_RESET;
        clear_walk();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_config_settings();
        test_back_to_back();
        test_pause_for_results();

        wait_idle();
        if (mismatch_count == 0 && pending_leases.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dolp_pkg.sv
rtl/dolp_front.sv
rtl/dolp_queue.sv
rtl/dolp_back.sv
rtl/dhcp_option_lease_parser.sv
tb/dhcp_option_lease_parser_tb.sv
